[hdl/thermal_packet_frame_reassembler_macros.svh]
// Assertion macros for the frame reassembler
`ifndef THERMAL_PACKET_FRAME_REASSEMBLER_MACROS_SVH
`define THERMAL_PACKET_FRAME_REASSEMBLER_MACROS_SVH

`ifndef ASSERT_OFF
`define TPFR_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TPFR_ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPFR_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define TPFR_ASSERT_CLK(lbl, clk, prop, msg)
`endif

`endif

[hdl/tpfr_pkg.sv]
package tpfr_pkg;

    localparam int FRAME_COLUMNS      = 160;
    localparam int FRAME_ROWS         = 120;
    localparam int SEGMENTS_PER_FRAME = 4;
    localparam int PACKETS_PER_SEG    = 60;

    localparam int SEG_W   = 4;
    localparam int PKT_W   = 12;
    localparam int IDX_W   = 7;
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 15;
    localparam int DATA_W  = 16;
    localparam int CNT_W   = 32;

    localparam int HALF_COLS  = FRAME_COLUMNS / 2;
    localparam int GLOBAL_MAX = 15 * PACKETS_PER_SEG + 4095;
    localparam int GLOBAL_W   = $clog2(GLOBAL_MAX + 1);
    localparam int ROW_W      = GLOBAL_W - 1;
    localparam int PROD_W     = ROW_W + $clog2(FRAME_COLUMNS + 1);
    localparam int IDX_CMP_W  = ($clog2(HALF_COLS + 1) > IDX_W) ?
                                $clog2(HALF_COLS + 1) : IDX_W;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_ACCEPT   = 3'd0,
        ST_DISCARD  = 3'd1,
        ST_INVALID  = 3'd2,
        ST_UNSYNCED = 3'd3,
        ST_ORDER    = 3'd4,
        ST_RESTART  = 3'd5,
        ST_ROW      = 3'd6
    } t_status;

    typedef struct packed {
        logic              header_valid;
        logic              discard;
        logic [SEG_W-1:0]  segment;
        logic [PKT_W-1:0]  pkt_num;
        logic [IDX_W-1:0]  word_index;
        logic [BYTE_W-1:0] pixel_high;
        logic [BYTE_W-1:0] pixel_low;
        logic              first;
        logic              start;
        logic              last_pos;
        logic              row_ok;
        logic [ROW_W-1:0]  row;
        logic              half;
        logic              idx_in_range;
        logic              idx_last;
    } t_item;

endpackage

[hdl/tpfr_front.sv]
module tpfr_front
    import tpfr_pkg::*;
(
    input  logic              i_header_valid,
    input  logic              i_discard,
    input  logic [SEG_W-1:0]  i_segment,
    input  logic [PKT_W-1:0]  i_pkt_num,
    input  logic [IDX_W-1:0]  i_word_index,
    input  logic [BYTE_W-1:0] i_pixel_high,
    input  logic [BYTE_W-1:0] i_pixel_low,
    output t_item             o_item
);

    logic [GLOBAL_W-1:0]  global_no;
    logic [IDX_CMP_W-1:0] idx_ext;

    always_comb begin
        global_no = GLOBAL_W'(i_segment) * GLOBAL_W'(PACKETS_PER_SEG)
                  + GLOBAL_W'(i_pkt_num);
        idx_ext   = IDX_CMP_W'(i_word_index);

        o_item.header_valid  = i_header_valid;
        o_item.discard       = i_discard;
        o_item.segment       = i_segment;
        o_item.pkt_num       = i_pkt_num;
        o_item.word_index    = i_word_index;
        o_item.pixel_high    = i_pixel_high;
        o_item.pixel_low     = i_pixel_low;
        o_item.first         = (i_word_index == '0);
        o_item.start         = (i_segment == '0) && (i_pkt_num == '0);
        o_item.last_pos      = (i_segment == SEG_W'(SEGMENTS_PER_FRAME - 1)) &&
                               (i_pkt_num == PKT_W'(PACKETS_PER_SEG - 1));
        o_item.row           = global_no[GLOBAL_W-1:1];
        o_item.half          = global_no[0];
        o_item.row_ok        = (global_no[GLOBAL_W-1:1] < ROW_W'(FRAME_ROWS));
        o_item.idx_in_range  = (idx_ext < IDX_CMP_W'(HALF_COLS));
        o_item.idx_last      = (idx_ext == IDX_CMP_W'(HALF_COLS - 1));
    end

endmodule

[hdl/tpfr_queue.sv]
module tpfr_queue
    import tpfr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr_ptr;
    logic [Q_AW-1:0]  r_rd_ptr;
    logic [Q_CW-1:0]  r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + Q_CW'(do_push) - Q_CW'(do_pop);
        end
    end

endmodule

[hdl/tpfr_back.sv]
`include "thermal_packet_frame_reassembler_macros.svh"

module tpfr_back
    import tpfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_item             i_item,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [2:0]        o_status,
    output logic              o_write_enable,
    output logic [ADDR_W-1:0] o_write_address,
    output logic [DATA_W-1:0] o_write_data,
    output logic              o_frame_done,
    output logic [CNT_W-1:0]  o_frame_count,
    output logic [CNT_W-1:0]  o_sync_error_count,
    output logic [CNT_W-1:0]  o_drop_count
);

    logic              r_in_sync, n_in_sync;
    logic [SEG_W-1:0]  r_exp_seg, n_exp_seg;
    logic [PKT_W-1:0]  r_exp_pkt, n_exp_pkt;
    logic              r_taken, n_taken;
    logic              r_closing, n_closing;
    logic [ADDR_W-1:0] r_base, n_base;
    t_status           r_held, n_held;
    logic [CNT_W-1:0]  r_frames, n_frames;
    logic [CNT_W-1:0]  r_errors, n_errors;
    logic [CNT_W-1:0]  r_drops, n_drops;

    logic              r_o_valid;
    t_status           r_o_status;
    logic              r_o_we, n_we;
    logic [ADDR_W-1:0] r_o_addr, n_addr;
    logic [DATA_W-1:0] r_o_data, n_data;
    logic              r_o_done, n_done;

    logic [SEG_W-1:0]  eff_seg;
    logic [PKT_W-1:0]  eff_pkt;
    logic [PROD_W-1:0] base_full;
    t_status           cand_status;
    logic              matched;

    assign o_q_pop = i_q_valid && (!r_o_valid || !i_stall);

    always_comb begin
        base_full = PROD_W'(i_item.row) * PROD_W'(FRAME_COLUMNS)
                  + (i_item.half ? PROD_W'(HALF_COLS) : '0);
        eff_seg   = r_in_sync ? r_exp_seg : '0;
        eff_pkt   = r_in_sync ? r_exp_pkt : '0;
        matched   = (i_item.segment == eff_seg) && (i_item.pkt_num == eff_pkt);
        cand_status = matched ? ST_ACCEPT : ST_RESTART;

        n_in_sync = r_in_sync;
        n_exp_seg = r_exp_seg;
        n_exp_pkt = r_exp_pkt;
        n_taken   = r_taken;
        n_closing = r_closing;
        n_base    = r_base;
        n_held    = r_held;
        n_frames  = r_frames;
        n_errors  = r_errors;
        n_drops   = r_drops;
        n_we      = 1'b0;
        n_addr    = '0;
        n_data    = '0;
        n_done    = 1'b0;

        if (i_item.first) begin
            n_taken   = 1'b0;
            n_closing = 1'b0;
            if (!i_item.header_valid) begin
                n_errors  = r_errors + 1'b1;
                n_drops   = r_drops + 1'b1;
                n_in_sync = 1'b0;
                n_exp_seg = '0;
                n_exp_pkt = '0;
                n_held    = ST_INVALID;
            end else if (i_item.discard) begin
                n_drops = r_drops + 1'b1;
                n_held  = ST_DISCARD;
            end else if (!r_in_sync && !i_item.start) begin
                n_held = ST_UNSYNCED;
            end else if (!matched && !i_item.start) begin
                n_errors  = r_errors + 1'b1;
                n_drops   = r_drops + 1'b1;
                n_in_sync = 1'b0;
                n_exp_seg = '0;
                n_exp_pkt = '0;
                n_held    = ST_ORDER;
            end else if (matched && !i_item.row_ok) begin
                n_errors  = r_errors + 1'b1;
                n_drops   = r_drops + 1'b1;
                n_in_sync = 1'b0;
                n_exp_seg = '0;
                n_exp_pkt = '0;
                n_held    = ST_ROW;
            end else begin
                if (!matched) begin
                    n_errors = r_errors + 1'b1;
                    n_drops  = r_drops + 1'b1;
                end
                n_in_sync = 1'b1;
                n_base    = base_full[ADDR_W-1:0];
                n_taken   = 1'b1;
                n_held    = cand_status;
                if (!matched) begin
                    n_exp_seg = '0;
                    n_exp_pkt = PKT_W'(1);
                end else begin
                    n_exp_seg = eff_seg;
                    n_exp_pkt = eff_pkt;
                end
                if (i_item.last_pos) begin
                    n_closing = 1'b1;
                    n_exp_seg = '0;
                    n_exp_pkt = '0;
                end else if (matched) begin
                    if ({1'b0, eff_pkt} + 1'b1 < (PKT_W + 1)'(PACKETS_PER_SEG)) begin
                        n_exp_pkt = eff_pkt + 1'b1;
                    end else begin
                        n_exp_pkt = '0;
                        n_exp_seg = eff_seg + 1'b1;
                    end
                end else if (PACKETS_PER_SEG == 1) begin
                    n_exp_pkt = '0;
                    n_exp_seg = SEG_W'(1);
                end
            end
        end

        if (n_taken && i_item.idx_in_range) begin
            n_we   = 1'b1;
            n_addr = n_base + ADDR_W'(i_item.word_index);
            n_data = {i_item.pixel_high, i_item.pixel_low};
            if (n_closing && i_item.idx_last) begin
                n_done    = 1'b1;
                n_frames  = r_frames + 1'b1;
                n_closing = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sync <= 1'b0;
            r_exp_seg <= '0;
            r_exp_pkt <= '0;
            r_taken   <= 1'b0;
            r_closing <= 1'b0;
            r_base    <= '0;
            r_held    <= ST_UNSYNCED;
            r_frames  <= '0;
            r_errors  <= '0;
            r_drops   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_in_sync <= n_in_sync;
                r_exp_seg <= n_exp_seg;
                r_exp_pkt <= n_exp_pkt;
                r_taken   <= n_taken;
                r_closing <= n_closing;
                r_base    <= n_base;
                r_held    <= n_held;
                r_frames  <= n_frames;
                r_errors  <= n_errors;
                r_drops   <= n_drops;
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_o_status <= n_held;
            r_o_we     <= n_we;
            r_o_addr   <= n_addr;
            r_o_data   <= n_data;
            r_o_done   <= n_done;
        end
    end

    assign o_valid            = r_o_valid;
    assign o_status           = r_o_status;
    assign o_write_enable     = r_o_we;
    assign o_write_address    = r_o_addr;
    assign o_write_data       = r_o_data;
    assign o_frame_done       = r_o_done;
    assign o_frame_count      = r_frames;
    assign o_sync_error_count = r_errors;
    assign o_drop_count       = r_drops;

    `TPFR_ASSERT_RST(a_closing_needs_taken, i_clk, i_rst_n, r_closing |-> r_taken, "closing without taken packet")
    `TPFR_ASSERT_RST(a_done_needs_write, i_clk, i_rst_n, (r_o_valid && r_o_done) |-> r_o_we, "frame done without write")
    `TPFR_ASSERT_RST(a_write_status, i_clk, i_rst_n, (r_o_valid && r_o_we) |-> ((r_o_status == ST_ACCEPT) || (r_o_status == ST_RESTART)), "write on dropped packet")
    `TPFR_ASSERT_RST(a_frames_on_done, i_clk, i_rst_n, (r_frames != $past(r_frames)) |-> (r_o_valid && r_o_done), "frame count moved without frame done")

endmodule

[hdl/thermal_packet_frame_reassembler.sv]
// Path: an accepted transaction is written into the queue, then popped into the output
// register, which presents it to the output handshake.
// Throughput: one transaction per cycle while the output is not stalled.
// Stalls: an output stall holds the output register and fills the 4-entry queue; the input
// stalls when the queue holds 4 and resumes at the edge after a pop frees an entry.
// Reset: synchronous, active low; clears sync state, counters and the queue.
module thermal_packet_frame_reassembler
    import tpfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_header_valid,
    input  logic              i_discard,
    input  logic [SEG_W-1:0]  i_segment,
    input  logic [PKT_W-1:0]  i_pkt_num,
    input  logic [IDX_W-1:0]  i_word_index,
    input  logic [BYTE_W-1:0] i_pixel_high,
    input  logic [BYTE_W-1:0] i_pixel_low,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [2:0]        o_status,
    output logic              o_write_enable,
    output logic [ADDR_W-1:0] o_write_address,
    output logic [DATA_W-1:0] o_write_data,
    output logic              o_frame_done,
    output logic [CNT_W-1:0]  o_frame_count,
    output logic [CNT_W-1:0]  o_sync_error_count,
    output logic [CNT_W-1:0]  o_drop_count
);

    t_item front_item;
    t_item q_item;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;

    assign o_stall = q_full;

    tpfr_front u_front (
        .i_header_valid  (i_header_valid),
        .i_discard       (i_discard),
        .i_segment       (i_segment),
        .i_pkt_num       (i_pkt_num),
        .i_word_index    (i_word_index),
        .i_pixel_high    (i_pixel_high),
        .i_pixel_low     (i_pixel_low),
        .o_item          (front_item)
    );

    tpfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    tpfr_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_valid),
        .i_item             (q_item),
        .o_q_pop            (q_pop),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_status           (o_status),
        .o_write_enable     (o_write_enable),
        .o_write_address    (o_write_address),
        .o_write_data       (o_write_data),
        .o_frame_done       (o_frame_done),
        .o_frame_count      (o_frame_count),
        .o_sync_error_count (o_sync_error_count),
        .o_drop_count       (o_drop_count)
    );

endmodule

[tb/sv/thermal_packet_frame_reassembler_tb.sv]
`timescale 1ns / 1ps

module thermal_packet_frame_reassembler_tb;
    import tpfr_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int RANDOM_BEATS = 1400;
    localparam int PACKETS_PER_FRAME = SEGMENTS_PER_FRAME * PACKETS_PER_SEG;

    typedef struct {
        logic              header_valid;
        logic              discard;
        logic [SEG_W-1:0]  segment;
        logic [PKT_W-1:0]  pkt_num;
        logic [IDX_W-1:0]  word_index;
        logic [BYTE_W-1:0] pixel_high;
        logic [BYTE_W-1:0] pixel_low;
    } t_video_beat;

    typedef struct {
        logic [2:0]        status;
        logic              write_enable;
        logic [ADDR_W-1:0] write_address;
        logic [DATA_W-1:0] write_data;
        logic              frame_done;
        logic [CNT_W-1:0]  frame_count;
        logic [CNT_W-1:0]  sync_error_count;
        logic [CNT_W-1:0]  drop_count;
    } t_pixel_write;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_header_valid = 1'b0;
    logic              i_discard = 1'b0;
    logic [SEG_W-1:0]  i_segment = '0;
    logic [PKT_W-1:0]  i_pkt_num = '0;
    logic [IDX_W-1:0]  i_word_index = '0;
    logic [BYTE_W-1:0] i_pixel_high = '0;
    logic [BYTE_W-1:0] i_pixel_low = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [2:0]        o_status;
    logic              o_write_enable;
    logic [ADDR_W-1:0] o_write_address;
    logic [DATA_W-1:0] o_write_data;
    logic              o_frame_done;
    logic [CNT_W-1:0]  o_frame_count;
    logic [CNT_W-1:0]  o_sync_error_count;
    logic [CNT_W-1:0]  o_drop_count;

    t_video_beat  beats_to_send[$];
    t_pixel_write writes_due[$];
    bit           in_fired = 1'b0;
    int           mismatches = 0;
    int           cycle_count = 0;
    int           quiet_cycles = 0;

    // reassembly state
    bit                synced = 1'b0;
    logic [SEG_W-1:0]  want_seg = '0;
    logic [PKT_W-1:0]  want_pkt = '0;
    bit                packet_live = 1'b0;
    logic [ADDR_W-1:0] row_base = '0;
    logic [CNT_W-1:0]  frames_done = '0;
    logic [CNT_W-1:0]  error_total = '0;
    logic [CNT_W-1:0]  drop_total = '0;
    t_status           held_status = ST_UNSYNCED;
    bit                last_packet = 1'b0;

    thermal_packet_frame_reassembler dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_header_valid    (i_header_valid),
        .i_discard         (i_discard),
        .i_segment         (i_segment),
        .i_pkt_num         (i_pkt_num),
        .i_word_index      (i_word_index),
        .i_pixel_high      (i_pixel_high),
        .i_pixel_low       (i_pixel_low),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_write_enable    (o_write_enable),
        .o_write_address   (o_write_address),
        .o_write_data      (o_write_data),
        .o_frame_done      (o_frame_done),
        .o_frame_count     (o_frame_count),
        .o_sync_error_count(o_sync_error_count),
        .o_drop_count      (o_drop_count)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit take_break();
        if (cycle_count >= 600 && cycle_count < 1400) return 1'b0;
        return $urandom_range(0, 99) < 19;
    endfunction

    function automatic void lose_sync();
        synced = 1'b0;
        want_seg = '0;
        want_pkt = '0;
    endfunction

    function automatic void count_fault();
        error_total = error_total + 1;
        drop_total = drop_total + 1;
    endfunction

    function automatic t_pixel_write reassemble_beat(t_video_beat b);
        t_pixel_write r;
        bit           start;
        bit           go;
        t_status      verdict;
        int           pos;
        int           row;
        r = '{default: '0};
        if (b.word_index == 0) begin
            start = (b.segment == 0) && (b.pkt_num == 0);
            packet_live = 1'b0;
            last_packet = 1'b0;
            if (!b.header_valid) begin
                count_fault();
                lose_sync();
                held_status = ST_INVALID;
            end else if (b.discard) begin
                drop_total = drop_total + 1;
                held_status = ST_DISCARD;
            end else if (!synced && !start) begin
                held_status = ST_UNSYNCED;
            end else begin
                synced = 1'b1;
                verdict = ST_ACCEPT;
                go = 1'b1;
                if (b.segment != want_seg || b.pkt_num != want_pkt) begin
                    count_fault();
                    if (start) begin
                        want_seg = '0;
                        want_pkt = '0;
                        verdict = ST_RESTART;
                    end else begin
                        lose_sync();
                        held_status = ST_ORDER;
                        go = 1'b0;
                    end
                end
                if (go) begin
                    pos = int'(b.segment) * PACKETS_PER_SEG + int'(b.pkt_num);
                    row = pos / 2;
                    if (row >= FRAME_ROWS) begin
                        count_fault();
                        lose_sync();
                        held_status = ST_ROW;
                    end else begin
                        row_base = ADDR_W'(row * FRAME_COLUMNS + (pos % 2) * HALF_COLS);
                        packet_live = 1'b1;
                        held_status = verdict;
                        if (int'(b.segment) == SEGMENTS_PER_FRAME - 1 &&
                            int'(b.pkt_num) == PACKETS_PER_SEG - 1) begin
                            last_packet = 1'b1;
                            want_seg = '0;
                            want_pkt = '0;
                        end else if (int'(want_pkt) + 1 < PACKETS_PER_SEG) begin
                            want_pkt = want_pkt + 1'b1;
                        end else begin
                            want_pkt = '0;
                            want_seg = want_seg + 1'b1;
                        end
                    end
                end
            end
        end
        if (packet_live && b.word_index < HALF_COLS) begin
            r.write_enable = 1'b1;
            r.write_address = row_base + b.word_index;
            r.write_data = {b.pixel_high, b.pixel_low};
            if (last_packet && b.word_index == HALF_COLS - 1) begin
                r.frame_done = 1'b1;
                frames_done = frames_done + 1;
                last_packet = 1'b0;
            end
        end
        r.status = held_status;
        r.frame_count = frames_done;
        r.sync_error_count = error_total;
        r.drop_count = drop_total;
        return r;
    endfunction

    function automatic void push_beat(int hv, int disc, int seg, int pkt, int idx,
                                      int hi, int lo);
        t_video_beat b;
        b.header_valid = hv[0];
        b.discard = disc[0];
        b.segment = SEG_W'(seg);
        b.pkt_num = PKT_W'(pkt);
        b.word_index = IDX_W'(idx);
        b.pixel_high = BYTE_W'(hi);
        b.pixel_low = BYTE_W'(lo);
        beats_to_send.push_back(b);
    endfunction

    function automatic void add_packet(int hv, int disc, int seg, int pkt, int extra,
                                       bit finish);
        int idx;
        push_beat(hv, disc, seg, pkt, 0, $urandom_range(0, 255), $urandom_range(0, 255));
        repeat (extra) begin
            idx = ($urandom_range(0, 9) == 0) ? $urandom_range(HALF_COLS, 127)
                                               : $urandom_range(1, HALF_COLS - 1);
            push_beat(hv, disc, seg, pkt, idx, $urandom_range(0, 255), $urandom_range(0, 255));
        end
        if (finish)
            push_beat(hv, disc, seg, pkt, HALF_COLS - 1, $urandom_range(0, 255),
                      $urandom_range(0, 255));
    endfunction

    function automatic int tail_beats();
        return ($urandom_range(0, 99) < 80) ? 0 : $urandom_range(1, 3);
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endfunction

    always @(negedge i_clk) begin : drive_beats
        t_video_beat b;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_stall <= 1'b0;
        end else begin
            if (!i_valid || in_fired) begin
                if (beats_to_send.size() > 0 && !take_break()) begin
                    b = beats_to_send.pop_front();
                    i_valid <= 1'b1;
                    i_header_valid <= b.header_valid;
                    i_discard <= b.discard;
                    i_segment <= b.segment;
                    i_pkt_num <= b.pkt_num;
                    i_word_index <= b.word_index;
                    i_pixel_high <= b.pixel_high;
                    i_pixel_low <= b.pixel_low;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= take_break();
        end
    end

    always @(posedge i_clk) begin : watch_writes
        t_video_beat  b;
        t_pixel_write want;
        bit           out_fired;
        if (!i_rst_n) begin
            in_fired = 1'b0;
        end else begin
            cycle_count++;
            in_fired = i_valid && !o_stall;
            out_fired = o_valid && !i_stall;
            if (in_fired) begin
                b.header_valid = i_header_valid;
                b.discard = i_discard;
                b.segment = i_segment;
                b.pkt_num = i_pkt_num;
                b.word_index = i_word_index;
                b.pixel_high = i_pixel_high;
                b.pixel_low = i_pixel_low;
                writes_due.push_back(reassemble_beat(b));
            end
            if (out_fired) begin
                if (writes_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected transaction, status 0x%0h", $time, o_status);
                end else begin
                    want = writes_due.pop_front();
                    compare_field("status", 32'(want.status), 32'(o_status));
                    compare_field("write_enable", 32'(want.write_enable), 32'(o_write_enable));
                    compare_field("write_address", 32'(want.write_address),
                                  32'(o_write_address));
                    compare_field("write_data", 32'(want.write_data), 32'(o_write_data));
                    compare_field("frame_done", 32'(want.frame_done), 32'(o_frame_done));
                    compare_field("frame_count", want.frame_count, o_frame_count);
                    compare_field("sync_error_count", want.sync_error_count,
                                  o_sync_error_count);
                    compare_field("drop_count", want.drop_count, o_drop_count);
                end
            end
            quiet_cycles = (in_fired || out_fired) ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("thermal_packet_frame_reassembler_tb failed");
                $finish;
            end
        end
    end

    initial begin
        int p;
        int seg;
        int pkt;
        int cut;
        int first_random;
        int clean_frames;
        bit broken;

        push_beat(1, 0, 2, 5, 0, 'h00, 'h00);
        push_beat(1, 0, 2, 5, 3, 'hFF, 'hFF);
        push_beat(0, 0, 15, 4095, 0, 'hFF, 'hFF);
        push_beat(1, 1, 0, 0, 0, 'h00, 'h00);
        push_beat(1, 0, 0, 0, 0, 'hFF, 'hFF);
        push_beat(1, 0, 0, 0, HALF_COLS - 1, 'h00, 'hFF);
        push_beat(1, 0, 0, 0, HALF_COLS, 'hFF, 'h00);
        push_beat(1, 0, 0, 0, 127, 'hA5, 'h5A);
        push_beat(1, 0, 0, 1, 0, 'hFF, 'h00);
        push_beat(1, 0, 0, 1, HALF_COLS - 1, 'h12, 'h34);
        push_beat(1, 0, 0, 0, 0, 'h80, 'h01);
        push_beat(1, 0, 0, 1, 0, 'h7F, 'hFE);
        push_beat(1, 0, 15, 4095, 0, 'hFF, 'hFF);
        push_beat(1, 0, 15, 4095, 1, 'hFF, 'hFF);
        push_beat(1, 0, 0, 0, 0, 'h00, 'h00);
        push_beat(1, 1, 0, 5, 0, 'h11, 'h22);
        push_beat(1, 0, 0, 1, 0, 'h33, 'h44);
        push_beat(0, 1, 0, 2, 0, 'h55, 'h66);
        push_beat(1, 0, 0, 0, 0, 'h77, 'h88);
        push_beat(1, 0, 1, 0, 0, 'h99, 'hAA);

        first_random = beats_to_send.size();
        clean_frames = 0;
        while (beats_to_send.size() - first_random < RANDOM_BEATS || clean_frames < 3) begin
            if ($urandom_range(0, 99) < 10) begin
                repeat ($urandom_range(1, 4))
                    add_packet($urandom_range(0, 1), $urandom_range(0, 1),
                               $urandom_range(0, 15), $urandom_range(0, 4095),
                               tail_beats(), 1'b0);
            end else begin
                broken = $urandom_range(0, 99) < 35;
                cut = broken ? $urandom_range(0, PACKETS_PER_FRAME - 1) : PACKETS_PER_FRAME;
                for (p = 0; p < PACKETS_PER_FRAME; p++) begin
                    seg = p / PACKETS_PER_SEG;
                    pkt = p % PACKETS_PER_SEG;
                    if (p == cut) begin
                        case ($urandom_range(0, 2))
                            0: add_packet(0, $urandom_range(0, 1), seg, pkt, tail_beats(),
                                          1'b0);
                            1: add_packet(1, 0, $urandom_range(0, 15), $urandom_range(0, 4095),
                                          tail_beats(), 1'b0);
                            default: add_packet(1, 0, 0, 0, tail_beats(), 1'b0);
                        endcase
                        break;
                    end
                    if ($urandom_range(0, 99) < 3)
                        add_packet(1, 1, $urandom_range(0, 15), $urandom_range(0, 4095),
                                   tail_beats(), 1'b0);
                    add_packet(1, 0, seg, pkt, tail_beats(),
                               p == PACKETS_PER_FRAME - 1 && $urandom_range(0, 9) != 0);
                end
                if (!broken) clean_frames++;
            end
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (beats_to_send.size() != 0 || i_valid || writes_due.size() != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("thermal_packet_frame_reassembler_tb passed");
        end else begin
            $display("thermal_packet_frame_reassembler_tb failed");
        end
        $finish;
    end

endmodule

[thermal_packet_frame_reassembler.f]
+incdir+hdl
hdl/tpfr_pkg.sv
hdl/tpfr_front.sv
hdl/tpfr_queue.sv
hdl/tpfr_back.sv
hdl/thermal_packet_frame_reassembler.sv
tb/sv/thermal_packet_frame_reassembler_tb.sv
